// ===== rtl/esdd_pkg.sv =====
package esdd_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned SceneCapDef   = 32;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned NumRegs       = 5;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_TYPE   = 3'd0,
    REG_POS    = 3'd1,
    REG_ROT    = 3'd2,
    REG_PHASE  = 3'd3,
    REG_FLAGS  = 3'd4
  } reg_idx_e;

  localparam logic [31:0] TypeMaskRst  = 32'd1;
  localparam logic [31:0] PosMaskRst   = 32'd2;
  localparam logic [31:0] RotMaskRst   = 32'd4;
  localparam logic [31:0] PhaseMaskRst = 32'd8;
  localparam logic [31:0] FlagsMaskRst = 32'd16;

  // Result codes.
  typedef enum logic [2:0] {
    OUT_MERGED = 3'd0,
    OUT_DONE   = 3'd1,
    OUT_TRUNC  = 3'd2,
    OUT_SCENE  = 3'd3,
    OUT_FULL   = 3'd4
  } outcome_e;

  // Work handed from the parser to the table side.
  typedef enum logic [1:0] {
    KIND_NOP   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_MERGE = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [31:0] type_m;
    logic [31:0] pos_m;
    logic [31:0] rot_m;
    logic [31:0] phase_m;
    logic [31:0] flags_m;
  } cfg_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  etype;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] rot;
    logic [31:0] phase;
    logic [31:0] flags;
  } entry_t;

  // Field hits, bit 0 type, 1 position, 2 rotation, 3 phase, 4 flags.
  typedef struct packed {
    logic        first;
    cmd_kind_e   kind;
    logic        delta;
    logic        has_post;
    outcome_e    post;
    logic [4:0]  hits;
    logic [31:0] mask;
    entry_t      ent;
  } cmd_t;

  function automatic logic [4:0] mask_hits(logic [31:0] m, cfg_t c);
    mask_hits = {|(m & c.flags_m), |(m & c.phase_m), |(m & c.rot_m),
                 |(m & c.pos_m), |(m & c.type_m)};
  endfunction

endpackage

// ===== rtl/esdd_fifo.sv =====
module esdd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  esdd_pkg::cmd_t    push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output esdd_pkg::cmd_t    pop_data_o
);

  localparam int unsigned PW = $clog2(esdd_pkg::QueueDepth);
  localparam int unsigned NW = $clog2(esdd_pkg::QueueDepth + 1);

  esdd_pkg::cmd_t slot_q [esdd_pkg::QueueDepth];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == NW'(esdd_pkg::QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slot_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(esdd_pkg::QueueDepth - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(esdd_pkg::QueueDepth - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(esdd_pkg::QueueDepth)) else $error("queue count out of range");

endmodule

// ===== rtl/esdd_front.sv =====
module esdd_front #(
  parameter int unsigned SCENE_CAP = esdd_pkg::SceneCapDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [7:0]        byte_i,
  input  logic              first_i,
  input  logic              last_i,
  input  esdd_pkg::cfg_t    cfg_i,
  output logic              push_o,
  output esdd_pkg::cmd_t    cmd_o,
  input  logic              full_i
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_DELTA, PH_SLEN, PH_SCENE, PH_COUNT, PH_ID, PH_TYPE, PH_MASK,
    PH_POSX, PH_POSY, PH_POSZ, PH_ROT, PH_PHASE, PH_FLAGS, PH_END
  } phase_e;

  phase_e         phase_q, phase_d, ph;
  logic [1:0]     bif_q, bif_d, bif;
  logic [23:0]    shift_q, shift_d;
  logic [15:0]    left_q, left_d;
  logic [7:0]     scene_q, scene_d;
  logic           delta_q, delta_d;
  logic           pend_first_q, pend_first_d;
  logic [31:0]    mask_q, mask_d;
  esdd_pkg::entry_t ent_q, ent_d;
  logic           accept, word_done, wide;
  logic [31:0]    acc, msrc;
  logic [4:0]     hits;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  // Phase that follows a group, by the received mask.
  function automatic phase_e next_after(phase_e cur, logic [4:0] h);
    if (cur < PH_POSX && h[1]) begin
      next_after = PH_POSX;
    end else if (cur < PH_ROT && h[2]) begin
      next_after = PH_ROT;
    end else if (cur < PH_PHASE && h[3]) begin
      next_after = PH_PHASE;
    end else if (cur < PH_FLAGS && h[4]) begin
      next_after = PH_FLAGS;
    end else begin
      next_after = PH_END;
    end
  endfunction

  // Byte assembly and field parsing.
  always_comb begin
    phase_d      = phase_q;
    bif_d        = bif_q;
    shift_d      = shift_q;
    left_d       = left_q;
    scene_d      = scene_q;
    delta_d      = delta_q;
    pend_first_d = pend_first_q;
    mask_d       = mask_q;
    ent_d        = ent_q;
    push_o       = 1'b0;
    cmd_o        = '0;
    ph           = first_i ? PH_DELTA : phase_q;
    bif          = first_i ? 2'd0 : bif_q;
    wide         = (ph == PH_ID) || (ph == PH_MASK) || (ph >= PH_POSX && ph <= PH_FLAGS);
    acc          = ((bif == 2'd0) ? 32'd0 : {8'd0, shift_q}) | ({24'd0, byte_i} << {bif, 3'b000});
    word_done    = (wide && bif == 2'd3) || (ph == PH_COUNT && bif == 2'd1);
    msrc         = (ph == PH_MASK) ? acc : mask_q;
    hits         = esdd_pkg::mask_hits(msrc, cfg_i);

    if (accept) begin
      if (first_i) begin
        pend_first_d = 1'b1;
        phase_d      = PH_DELTA;
        bif_d        = 2'd0;
        shift_d      = '0;
      end
      if (ph != PH_IDLE) begin
        if (wide || ph == PH_COUNT) begin
          if (word_done) begin
            bif_d   = 2'd0;
            shift_d = '0;
          end else begin
            bif_d   = bif + 2'd1;
            shift_d = acc[23:0];
          end
        end
        cmd_o.delta = delta_q;
        case (ph)
          PH_DELTA: begin
            delta_d     = (byte_i != 8'd0);
            cmd_o.delta = delta_d;
            phase_d     = PH_SLEN;
          end
          PH_SLEN: begin
            if ({1'b0, byte_i} >= 9'(SCENE_CAP)) begin
              push_o         = 1'b1;
              cmd_o.kind     = esdd_pkg::KIND_NOP;
              cmd_o.has_post = 1'b1;
              cmd_o.post     = esdd_pkg::OUT_SCENE;
              phase_d        = PH_IDLE;
            end else begin
              scene_d = byte_i;
              phase_d = (byte_i == 8'd0) ? PH_COUNT : PH_SCENE;
            end
          end
          PH_SCENE: begin
            if (scene_q > 8'd1) begin
              scene_d = scene_q - 8'd1;
            end else begin
              scene_d = 8'd0;
              phase_d = PH_COUNT;
            end
          end
          PH_TYPE: begin
            ent_d.etype = byte_i;
            phase_d     = PH_MASK;
          end
          default: begin
            if (word_done) begin
              case (ph)
                PH_COUNT: begin
                  left_d = acc[15:0];
                  if (!delta_q) begin
                    push_o     = 1'b1;
                    cmd_o.kind = esdd_pkg::KIND_CLEAR;
                  end
                  if (acc[15:0] == 16'd0) begin
                    push_o         = 1'b1;
                    cmd_o.has_post = 1'b1;
                    cmd_o.post     = esdd_pkg::OUT_DONE;
                    phase_d        = PH_IDLE;
                  end else begin
                    phase_d = PH_ID;
                  end
                end
                PH_ID: begin
                  ent_d.id = acc;
                  phase_d  = PH_TYPE;
                end
                PH_MASK: begin
                  mask_d      = acc;
                  ent_d.pos_x = '0;
                  ent_d.pos_y = '0;
                  ent_d.pos_z = '0;
                  ent_d.rot   = '0;
                  ent_d.phase = '0;
                  ent_d.flags = '0;
                  phase_d     = next_after(PH_MASK, hits);
                end
                PH_POSX: begin
                  ent_d.pos_x = acc;
                  phase_d     = PH_POSY;
                end
                PH_POSY: begin
                  ent_d.pos_y = acc;
                  phase_d     = PH_POSZ;
                end
                PH_POSZ: begin
                  ent_d.pos_z = acc;
                  phase_d     = next_after(PH_POSZ, hits);
                end
                PH_ROT: begin
                  ent_d.rot = acc;
                  phase_d   = next_after(PH_ROT, hits);
                end
                PH_PHASE: begin
                  ent_d.phase = acc;
                  phase_d     = next_after(PH_PHASE, hits);
                end
                PH_FLAGS: begin
                  ent_d.flags = acc;
                  phase_d     = PH_END;
                end
                default: begin
                  phase_d = PH_IDLE;
                end
              endcase
            end
          end
        endcase

        // Entity complete: hand it over for the merge.
        if (phase_d == PH_END) begin
          push_o     = 1'b1;
          cmd_o.kind = esdd_pkg::KIND_MERGE;
          cmd_o.hits = hits;
          cmd_o.mask = mask_d;
          cmd_o.ent  = ent_d;
          if (left_q <= 16'd1) begin
            left_d         = 16'd0;
            cmd_o.has_post = 1'b1;
            cmd_o.post     = esdd_pkg::OUT_DONE;
            phase_d        = PH_IDLE;
          end else begin
            left_d  = left_q - 16'd1;
            phase_d = PH_ID;
          end
        end

        // Buffer ran out before the payload ended.
        if (last_i && phase_d != PH_IDLE) begin
          push_o         = 1'b1;
          cmd_o.has_post = 1'b1;
          cmd_o.post     = esdd_pkg::OUT_TRUNC;
          phase_d        = PH_IDLE;
          bif_d          = 2'd0;
          shift_d        = '0;
        end

        if (push_o) begin
          cmd_o.first  = pend_first_d;
          pend_first_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bif_q        <= '0;
      shift_q      <= '0;
      left_q       <= '0;
      scene_q      <= '0;
      delta_q      <= 1'b0;
      pend_first_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bif_q        <= bif_d;
      shift_q      <= shift_d;
      left_q       <= left_d;
      scene_q      <= scene_d;
      delta_q      <= delta_d;
      pend_first_q <= pend_first_d;
    end
  end

  // Entity fields under assembly.
  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    ent_q  <= ent_d;
  end

endmodule

// ===== rtl/esdd_back.sv =====
module esdd_back #(
  parameter int unsigned TABLE_DEPTH = esdd_pkg::TableDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  esdd_pkg::cmd_t    cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [271:0]      out_data_o,
  output logic [2:0]        out_user_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SRD, ST_SCMP, ST_APPEND, ST_POST
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             abort_q, abort_d;
  esdd_pkg::cmd_t   cur_q, cur_d;
  esdd_pkg::entry_t mem_q [TABLE_DEPTH];
  esdd_pkg::entry_t rd_q, merged, wdata;
  logic             we;
  logic [IW-1:0]    waddr;
  logic             out_valid_q, out_valid_d;
  logic [271:0]     out_data_q, out_data_d;
  logic [2:0]       out_user_q, out_user_d;
  logic             out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Stored entry with the masked fields taken from the new entity.
  always_comb begin
    merged = rd_q;
    if (cur_q.hits[0]) begin
      merged.etype = cur_q.ent.etype;
    end
    if (cur_q.hits[1]) begin
      merged.pos_x = cur_q.ent.pos_x;
      merged.pos_y = cur_q.ent.pos_y;
      merged.pos_z = cur_q.ent.pos_z;
    end
    if (cur_q.hits[2]) begin
      merged.rot = cur_q.ent.rot;
    end
    if (cur_q.hits[3]) begin
      merged.phase = cur_q.ent.phase;
    end
    if (cur_q.hits[4]) begin
      merged.flags = cur_q.ent.flags;
    end
  end

  // Table sequencer: clear, or a linear id search in delta mode, then update or append.
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    abort_d     = abort_q;
    cur_d       = cur_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = cur_q.ent;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          if (cmd_i.first) begin
            abort_d = 1'b0;
          end
          if (!abort_q || cmd_i.first) begin
            cur_d = cmd_i;
            case (cmd_i.kind)
              esdd_pkg::KIND_CLEAR: begin
                occ_d   = '0;
                state_d = cmd_i.has_post ? ST_POST : ST_IDLE;
              end
              esdd_pkg::KIND_MERGE: begin
                idx_d   = '0;
                state_d = (cmd_i.delta && occ_q != '0) ? ST_SRD : ST_APPEND;
              end
              default: begin
                state_d = cmd_i.has_post ? ST_POST : ST_IDLE;
              end
            endcase
          end
        end
      end
      ST_SRD: begin
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        if (rd_q.id == cur_q.ent.id) begin
          if (out_free) begin
            we          = 1'b1;
            wdata       = merged;
            out_valid_d = 1'b1;
            out_user_d  = esdd_pkg::OUT_MERGED;
            out_data_d  = {merged.flags, merged.phase, merged.rot, merged.pos_z,
                           merged.pos_y, merged.pos_x, cur_q.mask, merged.etype,
                           merged.id, cur_q.delta, 7'(idx_q)};
            state_d     = cur_q.has_post ? ST_POST : ST_IDLE;
          end
        end else if (CW'(idx_q) + CW'(1) == occ_q) begin
          state_d = ST_APPEND;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_SRD;
        end
      end
      ST_APPEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (occ_q >= CW'(TABLE_DEPTH)) begin
            out_user_d = esdd_pkg::OUT_FULL;
            out_data_d = {264'd0, cur_q.delta, 7'(occ_q)};
            abort_d    = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            we         = 1'b1;
            waddr      = occ_q[IW-1:0];
            out_user_d = esdd_pkg::OUT_MERGED;
            out_data_d = {cur_q.ent.flags, cur_q.ent.phase, cur_q.ent.rot,
                          cur_q.ent.pos_z, cur_q.ent.pos_y, cur_q.ent.pos_x,
                          cur_q.mask, cur_q.ent.etype, cur_q.ent.id,
                          cur_q.delta, 7'(occ_q)};
            occ_d      = occ_q + CW'(1);
            state_d    = cur_q.has_post ? ST_POST : ST_IDLE;
          end
        end
      end
      ST_POST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_user_d  = cur_q.post;
          out_data_d  = {264'd0, cur_q.delta, 7'(occ_q)};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      idx_q       <= '0;
      abort_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      abort_q     <= abort_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  // Entity table, one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(TABLE_DEPTH)) else $error("table count above depth");
  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCMP |-> CW'(idx_q) < occ_q) else $error("search past occupied slots");
  a_abort_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(abort_q) |-> $past(state_q) == ST_APPEND && out_user_q == esdd_pkg::OUT_FULL)
    else $error("abort without table full result");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == ST_IDLE && valid_i) else $error("pop outside idle");

endmodule

// ===== rtl/entity_snapshot_delta_decoder_core.sv =====
// An entity completed by a byte passes through the queue, the sequencer and the output
// register on an append; in delta mode an id search first reads and compares the
// occupied slots one at a time, stopping at a match.
// Throughput: one byte per cycle while the queue is not full; the single-port id search in
// the table sequencer sets delta-mode entity rate; a two-entry queue decouples the parser.
// Reset (asynchronous, active low) empties the table count, the queue and the
// parser; configuration registers return to their reset masks. Table data is not cleared.
module entity_snapshot_delta_decoder_core #(
  parameter int unsigned TABLE_DEPTH = esdd_pkg::TableDepthDef,
  parameter int unsigned SCENE_CAP   = esdd_pkg::SceneCapDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] byte_value
  input  logic         s_axis_tuser_i,   // [0] first_byte
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [6:0] slot_or_count, [7] delta_mode, [39:8] id of the entry, [47:40] entity_type,
  // [79:48] component mask as received, [111:80] pos_x, [143:112] pos_y, [175:144] pos_z,
  // [207:176] rotation, [239:208] phase_value, [271:240] flag_word
  output logic [271:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,   // [2:0] outcome
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  esdd_pkg::cfg_t cfg_q;
  esdd_pkg::cmd_t push_cmd, pop_cmd;
  logic           push, pop, q_full, q_valid, wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_m  <= esdd_pkg::TypeMaskRst;
      cfg_q.pos_m   <= esdd_pkg::PosMaskRst;
      cfg_q.rot_m   <= esdd_pkg::RotMaskRst;
      cfg_q.phase_m <= esdd_pkg::PhaseMaskRst;
      cfg_q.flags_m <= esdd_pkg::FlagsMaskRst;
    end else if (wr_en) begin
      case (reg_idx)
        esdd_pkg::REG_TYPE:  cfg_q.type_m  <= pwdata;
        esdd_pkg::REG_POS:   cfg_q.pos_m   <= pwdata;
        esdd_pkg::REG_ROT:   cfg_q.rot_m   <= pwdata;
        esdd_pkg::REG_PHASE: cfg_q.phase_m <= pwdata;
        esdd_pkg::REG_FLAGS: cfg_q.flags_m <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      esdd_pkg::REG_TYPE:  prdata = cfg_q.type_m;
      esdd_pkg::REG_POS:   prdata = cfg_q.pos_m;
      esdd_pkg::REG_ROT:   prdata = cfg_q.rot_m;
      esdd_pkg::REG_PHASE: prdata = cfg_q.phase_m;
      esdd_pkg::REG_FLAGS: prdata = cfg_q.flags_m;
      default:             prdata = '0;
    endcase
  end

  esdd_front #(
    .SCENE_CAP (SCENE_CAP)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .byte_i  (s_axis_tdata_i),
    .first_i (s_axis_tuser_i),
    .last_i  (s_axis_tlast_i),
    .cfg_i   (cfg_q),
    .push_o  (push),
    .cmd_o   (push_cmd),
    .full_i  (q_full)
  );

  esdd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_cmd)
  );

  esdd_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

// ===== test/entity_snapshot_delta_decoder_core_tb.sv =====
module entity_snapshot_delta_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 64;
  localparam int SceneCap = 32;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 200;

  typedef enum int {
    PP_IDLE, PP_DELTA, PP_SLEN, PP_SCENE, PP_COUNT, PP_ID, PP_TYPE, PP_MASK,
    PP_POSX, PP_POSY, PP_POSZ, PP_ROT, PP_PHASE, PP_FLAGS, PP_END
  } parse_ph_e;

  typedef struct {
    esdd_pkg::outcome_e oc;
    logic [6:0]  slot;
    logic        delta;
    logic [31:0] id;
    logic [7:0]  etype;
    logic [31:0] mask;
    logic [31:0] px, py, pz, rot, ph, fl;
  } merge_rec_t;

  // Mirror of the parser and entity table; keeps the results still owed by the block.
  class snapshot_board;
    logic [31:0] cfg[esdd_pkg::NumRegs];
    logic [31:0] t_id[Depth];
    logic [7:0]  t_type[Depth];
    logic [31:0] t_px[Depth], t_py[Depth], t_pz[Depth];
    logic [31:0] t_rot[Depth], t_ph[Depth], t_fl[Depth];
    int          occ;
    parse_ph_e   ph;
    int          bif;
    logic [31:0] shift;
    int          ent_left;
    int          scene_left;
    bit          dflag;
    logic [31:0] p_id, p_mask, p_x, p_y, p_z, p_rot, p_ph, p_fl;
    logic [7:0]  p_type;
    merge_rec_t  owed[$];
    int          errors;
    int          n_merged;
    int          n_final;

    function new();
      cfg[esdd_pkg::REG_TYPE] = esdd_pkg::TypeMaskRst;
      cfg[esdd_pkg::REG_POS] = esdd_pkg::PosMaskRst;
      cfg[esdd_pkg::REG_ROT] = esdd_pkg::RotMaskRst;
      cfg[esdd_pkg::REG_PHASE] = esdd_pkg::PhaseMaskRst;
      cfg[esdd_pkg::REG_FLAGS] = esdd_pkg::FlagsMaskRst;
      occ = 0;
      ph = PP_IDLE;
      bif = 0;
      shift = '0;
      ent_left = 0;
      scene_left = 0;
      dflag = 0;
      {p_id, p_mask, p_x, p_y, p_z, p_rot, p_ph, p_fl, p_type} = '0;
      errors = 0;
      n_merged = 0;
      n_final = 0;
    endfunction

    function bit hit(esdd_pkg::reg_idx_e r);
      return (p_mask & cfg[r]) != 0;
    endfunction

    function parse_ph_e next_after(parse_ph_e cur);
      if (cur < PP_POSX && hit(esdd_pkg::REG_POS)) return PP_POSX;
      if (cur < PP_ROT && hit(esdd_pkg::REG_ROT)) return PP_ROT;
      if (cur < PP_PHASE && hit(esdd_pkg::REG_PHASE)) return PP_PHASE;
      if (cur < PP_FLAGS && hit(esdd_pkg::REG_FLAGS)) return PP_FLAGS;
      return PP_END;
    endfunction

    function void owe(esdd_pkg::outcome_e oc, int slot, bit entry);
      merge_rec_t r;
      r = '{oc: esdd_pkg::OUT_MERGED, default: '0};
      r.oc = oc;
      r.slot = slot[6:0];
      r.delta = dflag;
      if (entry) begin
        r.id = t_id[slot];
        r.etype = t_type[slot];
        r.mask = p_mask;
        r.px = t_px[slot];
        r.py = t_py[slot];
        r.pz = t_pz[slot];
        r.rot = t_rot[slot];
        r.ph = t_ph[slot];
        r.fl = t_fl[slot];
      end
      owed.push_back(r);
    endfunction

    // Returns the slot written, or -1 when an append finds the table full.
    function int merge_entity();
      int i;
      if (dflag) begin
        for (i = 0; i < occ; i++) begin
          if (t_id[i] == p_id) begin
            if (hit(esdd_pkg::REG_TYPE)) t_type[i] = p_type;
            if (hit(esdd_pkg::REG_POS)) begin
              t_px[i] = p_x;
              t_py[i] = p_y;
              t_pz[i] = p_z;
            end
            if (hit(esdd_pkg::REG_ROT)) t_rot[i] = p_rot;
            if (hit(esdd_pkg::REG_PHASE)) t_ph[i] = p_ph;
            if (hit(esdd_pkg::REG_FLAGS)) t_fl[i] = p_fl;
            return i;
          end
        end
      end
      if (occ >= Depth) return -1;
      i = occ;
      occ++;
      t_id[i] = p_id;
      t_type[i] = p_type;
      t_px[i] = p_x;
      t_py[i] = p_y;
      t_pz[i] = p_z;
      t_rot[i] = p_rot;
      t_ph[i] = p_ph;
      t_fl[i] = p_fl;
      return i;
    endfunction

    function void note_byte(logic [7:0] b, bit first, bit last);
      int wd;
      int slot;
      logic [31:0] acc;
      logic [31:0] v;
      bit done;
      wd = 0;
      v = '0;
      done = 0;
      if (first) begin
        ph = PP_DELTA;
        bif = 0;
        shift = '0;
      end
      if (ph == PP_IDLE) return;

      // Gather little-endian count and word fields.
      if (ph == PP_COUNT) wd = 2;
      else if (ph == PP_ID || ph == PP_MASK || (ph >= PP_POSX && ph <= PP_FLAGS)) wd = 4;
      if (wd != 0) begin
        acc = (bif == 0 ? 32'd0 : shift) | (32'(b) << (8 * bif));
        if (bif + 1 >= wd) begin
          v = acc;
          done = 1;
          bif = 0;
          shift = '0;
        end else begin
          bif++;
          shift = acc;
        end
      end

      case (ph)
        PP_DELTA: begin
          dflag = b != 0;
          ph = PP_SLEN;
        end
        PP_SLEN: begin
          if (b >= SceneCap) begin
            owe(esdd_pkg::OUT_SCENE, occ, 0);
            ph = PP_IDLE;
            return;
          end
          scene_left = b;
          ph = b == 0 ? PP_COUNT : PP_SCENE;
        end
        PP_SCENE: begin
          if (scene_left > 0) scene_left--;
          if (scene_left == 0) ph = PP_COUNT;
        end
        PP_TYPE: begin
          p_type = b;
          ph = PP_MASK;
        end
        default: begin
          if (done) begin
            case (ph)
              PP_COUNT: begin
                if (!dflag) occ = 0;
                ent_left = v[15:0];
                if (ent_left == 0) begin
                  owe(esdd_pkg::OUT_DONE, occ, 0);
                  ph = PP_IDLE;
                  return;
                end
                ph = PP_ID;
              end
              PP_ID: begin
                p_id = v;
                ph = PP_TYPE;
              end
              PP_MASK: begin
                p_mask = v;
                {p_x, p_y, p_z, p_rot, p_ph, p_fl} = '0;
                ph = next_after(PP_MASK);
              end
              PP_POSX: begin
                p_x = v;
                ph = PP_POSY;
              end
              PP_POSY: begin
                p_y = v;
                ph = PP_POSZ;
              end
              PP_POSZ: begin
                p_z = v;
                ph = next_after(PP_POSZ);
              end
              PP_ROT: begin
                p_rot = v;
                ph = next_after(PP_ROT);
              end
              PP_PHASE: begin
                p_ph = v;
                ph = next_after(PP_PHASE);
              end
              PP_FLAGS: begin
                p_fl = v;
                ph = PP_END;
              end
              default: ph = PP_IDLE;
            endcase
          end
        end
      endcase

      if (ph == PP_END) begin
        slot = merge_entity();
        if (slot < 0) begin
          owe(esdd_pkg::OUT_FULL, occ, 0);
          ph = PP_IDLE;
          return;
        end
        owe(esdd_pkg::OUT_MERGED, slot, 1);
        if (ent_left > 0) ent_left--;
        if (ent_left == 0) begin
          owe(esdd_pkg::OUT_DONE, occ, 0);
          ph = PP_IDLE;
          return;
        end
        ph = PP_ID;
      end

      // The buffer ran out before the snapshot was complete.
      if (last && ph != PP_IDLE) begin
        owe(esdd_pkg::OUT_TRUNC, occ, 0);
        ph = PP_IDLE;
        bif = 0;
        shift = '0;
      end
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] oc, logic [271:0] d);
      merge_rec_t r;
      if (owed.size() == 0) begin
        $error("result with nothing owed: outcome %0d", oc);
        errors++;
        return;
      end
      r = owed.pop_front();
      if (r.oc == esdd_pkg::OUT_MERGED) n_merged++;
      else n_final++;
      cmp("outcome", 32'(r.oc), 32'(oc));
      cmp("slot_or_count", 32'(r.slot), 32'(d[6:0]));
      cmp("delta_mode", 32'(r.delta), 32'(d[7]));
      cmp("id_word", r.id, d[39:8]);
      cmp("entity_type", 32'(r.etype), 32'(d[47:40]));
      cmp("mask_word", r.mask, d[79:48]);
      cmp("pos_x", r.px, d[111:80]);
      cmp("pos_y", r.py, d[143:112]);
      cmp("pos_z", r.pz, d[175:144]);
      cmp("rotation", r.rot, d[207:176]);
      cmp("phase_value", r.ph, d[239:208]);
      cmp("flag_word", r.fl, d[271:240]);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         s_axis_tlast_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [271:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  snapshot_board board;
  bit            calm;
  int            n_bytes;
  int            n_cfg;
  int            stall;
  logic [31:0]   id_pool[80];

  entity_snapshot_delta_decoder_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // The result side stalls at random except during the calm stretch.
  always @(negedge clk_i) begin
    m_axis_tready_i <= calm ? 1'b1 : ($urandom_range(99) >= 37);
  end

  // Check results and watch for a hung block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        board.check_result(m_axis_tuser_o, m_axis_tdata_o);
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o) ||
          (psel && penable)) begin
        stall = 0;
      end else begin
        stall = stall + 1;
      end
      if (stall >= StallLimit) begin
        $display("timeout with %0d results still owed", board.owed.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit first, input bit last);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 37) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = b;
    s_axis_tuser_i = first;
    s_axis_tlast_i = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_byte(b, first, last);
    n_bytes++;
  endtask

  // Masks change only once the block has drained and finished any id search.
  task automatic set_masks(input logic [31:0] m0, m1, m2, m3, m4);
    logic [31:0] vals[esdd_pkg::NumRegs];
    esdd_pkg::reg_idx_e r;
    vals = '{m0, m1, m2, m3, m4};
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    for (int i = 0; i < esdd_pkg::NumRegs; i++) begin
      r = esdd_pkg::reg_idx_e'(i);
      @(negedge clk_i);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {r, 2'b00};
      pwdata = vals[i];
      @(negedge clk_i);
      penable = 1'b1;
      do @(posedge clk_i); while (!pready);
      board.cfg[r] = vals[i];
      n_cfg++;
      @(negedge clk_i);
      psel = 1'b0;
      penable = 1'b0;
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Builds one snapshot payload and streams the first cut bytes of it (all when cut < 1 or cut >= its length).
  task automatic send_snapshot(input bit dm, input int slen, input int cnt, input int cut,
                               input bit seq_ids, input bit end_last);
    logic [7:0]  q[$];
    logic [31:0] id, mask, w;
    int          ents, nw, n;
    q.push_back(dm ? 8'($urandom_range(1, 255)) : 8'h00);
    q.push_back(8'(slen));
    if (slen < SceneCap) begin
      for (int i = 0; i < slen; i++) q.push_back(8'($urandom));
      q.push_back(cnt[7:0]);
      q.push_back(cnt[15:8]);
      ents = cnt > 70 ? 70 : cnt;
      for (int e = 0; e < ents; e++) begin
        id = seq_ids ? 32'(e) : id_pool[$urandom_range(79)];
        case ($urandom_range(3))
          0: mask = $urandom;
          1: mask = 32'h0;
          default: mask = 32'($urandom_range(31));
        endcase
        if (seq_ids) mask = 32'h0;
        for (int k = 0; k < 4; k++) q.push_back(id[8*k +: 8]);
        q.push_back(8'($urandom));
        for (int k = 0; k < 4; k++) q.push_back(mask[8*k +: 8]);
        nw = ((mask & board.cfg[esdd_pkg::REG_POS]) != 0 ? 3 : 0) +
             ((mask & board.cfg[esdd_pkg::REG_ROT]) != 0 ? 1 : 0) +
             ((mask & board.cfg[esdd_pkg::REG_PHASE]) != 0 ? 1 : 0) +
             ((mask & board.cfg[esdd_pkg::REG_FLAGS]) != 0 ? 1 : 0);
        for (int j = 0; j < nw; j++) begin
          w = pick_word();
          for (int k = 0; k < 4; k++) q.push_back(w[8*k +: 8]);
        end
      end
    end
    n = (cut >= 1 && cut < q.size()) ? cut : q.size();
    for (int i = 0; i < n; i++) push_byte(q[i], i == 0, end_last && i == n - 1);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'b0, $urandom_range(3) == 0);
  endtask

  initial begin
    int slen, cnt, cut, sel;
    board = new();
    calm = 0;
    n_bytes = 0;
    n_cfg = 0;
    stall = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    s_axis_tlast_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 80; i++) id_pool[i] = $urandom;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: idle noise, full then delta, scene limits, empty count, truncation,
    // restart in mid-payload, and an append past a full table with no idling.
    send_noise(3);
    send_snapshot(0, 0, 2, -1, 0, 1);
    send_snapshot(1, 3, 2, -1, 0, 0);
    send_snapshot(0, 32, 1, -1, 0, 1);
    send_snapshot(1, 255, 1, -1, 0, 0);
    send_snapshot(0, 31, 0, -1, 0, 1);
    send_snapshot(1, 0, 0, -1, 0, 1);
    send_snapshot(1, 1, 3, 12, 0, 1);
    send_snapshot(1, 0, 2, 9, 0, 0);
    send_snapshot(1, 0, 65535, 12, 0, 1);
    calm = 1;
    send_snapshot(0, 0, 65, -1, 1, 1);
    calm = 0;
    send_noise(2);
    set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_snapshot(0, 2, 1, -1, 0, 1);
    send_snapshot(1, 0, 1, -1, 0, 1);
    set_masks(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_snapshot(1, 0, 2, -1, 0, 1);

    // Random snapshots, mostly well formed, under changing mask settings.
    while (n_bytes < 880) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        case ($urandom_range(3))
          0: set_masks(esdd_pkg::TypeMaskRst, esdd_pkg::PosMaskRst, esdd_pkg::RotMaskRst,
                       esdd_pkg::PhaseMaskRst, esdd_pkg::FlagsMaskRst);
          1: set_masks(32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'h0);
          2: set_masks(32'h1 << $urandom_range(31), 32'h1 << $urandom_range(31),
                       32'h1 << $urandom_range(31), 32'h1 << $urandom_range(31),
                       32'h1 << $urandom_range(31));
          default: set_masks($urandom, $urandom, $urandom, $urandom, $urandom);
        endcase
      end else if (sel < 12) begin
        send_noise($urandom_range(1, 4));
      end else begin
        sel = $urandom_range(99);
        slen = sel < 88 ? $urandom_range(0, 5) : (sel < 94 ? 31 : $urandom_range(32, 255));
        sel = $urandom_range(99);
        cnt = sel < 85 ? $urandom_range(1, 4) : (sel < 90 ? 0 :
              (sel < 95 ? $urandom_range(0, 65535) : $urandom_range(20, 40)));
        cut = $urandom_range(4) == 0 ? $urandom_range(1, 60) : -1;
        send_snapshot($urandom_range(9) < 7, slen, cnt, cut, 0, $urandom_range(4) != 0);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d payload bytes across %0d mask register writes", n_bytes, n_cfg);
    $display("checked %0d entity merges and %0d closing results",
             board.n_merged, board.n_final);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
